### rtl/eps_pkg.sv
// ----------------------------------------------------------------------------
// Earliest packet call scheduler package
// Shared widths, defaults and status codes of the scheduler and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eps_pkg;

    localparam int MAX_CALLS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int IVL_W        = 20;
    localparam int FIELD_W      = 32;
    localparam int SLOT_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 96;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 40;
    localparam int M_TUSER_W    = 2;

    localparam logic [IVL_W-1:0] PKT_IVL_RST = 20'd20000;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_REQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PACKET = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

`default_nettype wire

### rtl/earliest_packet_call_scheduler.sv
// ----------------------------------------------------------------------------
// Earliest packet call scheduler
// Call table with add and request commands; serves the earliest packet time.
// ----------------------------------------------------------------------------
// The input channel carries one command per item: the command in tuser and
// the start, end and current times in tdata. An add stores the call in the
// lowest free slot or reports a full table. A request drops expired calls,
// returns the earliest next-packet time with its slot and then advances that
// time by the packet interval, saturating at the largest time value.
// The configuration channel writes the packet interval; it is always ready.
//
// Both commands walk the table one slot per cycle: an add through the valid
// bits, a request through a single compare unit and the one read port of the
// call memories. An add passes through S_ADD and S_OUT, a request through
// S_REQ, S_UPD and S_OUT, before the result is shown. The input is not ready
// while a command is under way. Each item gives exactly one result, held in
// an output register until it is taken; a stalled receiver holds the block
// in its final state only when a further result is ready to be shown.
// Reset clears the valid bits and the control state and loads the default
// interval of 20000 microseconds; the call memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_packet_call_scheduler
    import eps_pkg::*;
#(
    parameter int MAX_CALLS = MAX_CALLS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: start_time, end_time, now (lowest bits first)
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: cmd
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata: arrival_time, slot, zero padding (lowest bits first)
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // tuser: status
    output logic [M_TUSER_W-1:0]      o_m_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [IVL_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (MAX_CALLS > 1) ? $clog2(MAX_CALLS) : 1;
    localparam int SUM_W = ((TIME_BITS > IVL_W) ? TIME_BITS : IVL_W) + 1;
    localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(MAX_CALLS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_REQ  = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [IVL_W-1:0]      r_ivl, n_ivl;
    logic [MAX_CALLS-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_issued, n_issued;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_cmd;
    logic [TIME_BITS-1:0]  r_start, r_end, r_now;
    logic [TIME_BITS-1:0]  r_rd_start, r_rd_end, r_rd_np;
    logic                  r_found, n_found;
    logic [TIME_BITS-1:0]  r_best_np, n_best_np;
    logic [TIME_BITS-1:0]  r_best_start, n_best_start;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [TIME_BITS-1:0]  r_res_time, n_res_time;
    logic [IDX_W-1:0]      r_res_slot, n_res_slot;
    logic                  r_out_vld, n_out_vld;
    logic [M_TDATA_W-1:0]  r_out_tdata, n_out_tdata;
    logic [M_TUSER_W-1:0]  r_out_tuser, n_out_tuser;

    logic [TIME_BITS-1:0]  r_mem_start [MAX_CALLS];
    logic [TIME_BITS-1:0]  r_mem_end   [MAX_CALLS];
    logic [TIME_BITS-1:0]  r_mem_np    [MAX_CALLS];

    logic                  w_add_we;
    logic                  w_np_we;
    logic [IDX_W-1:0]      w_np_addr;
    logic [TIME_BITS-1:0]  w_np_data;

    logic                  w_s_acc;
    logic [TIME_BITS+FIELD_W-1:0] w_in_start, w_in_end, w_in_now;
    logic [TIME_BITS+FIELD_W-1:0] w_res_time_ext;
    logic [IDX_W+SLOT_W-1:0]      w_res_slot_ext;
    logic [SUM_W-1:0]      w_sum;
    logic [TIME_BITS-1:0]  w_next_np;
    logic                  w_better;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_tdata;
    assign o_m_tuser   = r_out_tuser;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_in_start = {{TIME_BITS{1'b0}}, i_s_tdata[FIELD_W-1:0]};
    assign w_in_end   = {{TIME_BITS{1'b0}}, i_s_tdata[2*FIELD_W-1:FIELD_W]};
    assign w_in_now   = {{TIME_BITS{1'b0}}, i_s_tdata[3*FIELD_W-1:2*FIELD_W]};

    assign w_res_time_ext = {{FIELD_W{1'b0}}, r_res_time};
    assign w_res_slot_ext = {{SLOT_W{1'b0}}, r_res_slot};

    assign w_sum     = SUM_W'(r_best_np) + SUM_W'(r_ivl);
    assign w_next_np = (w_sum >= SUM_W'(TIME_MASK)) ? TIME_MASK : w_sum[TIME_BITS-1:0];

    assign w_better = !r_found || (r_rd_np < r_best_np)
                      || ((r_rd_np == r_best_np) && (r_rd_start < r_best_start));

    assign w_add_we  = (r_state == S_ADD) && !r_valid[r_idx];
    assign w_np_we   = w_add_we || ((r_state == S_UPD) && r_found);
    assign w_np_addr = w_add_we ? r_idx : r_best_idx;
    assign w_np_data = w_add_we ? r_start : w_next_np;

    always_comb begin
        n_state      = r_state;
        n_ivl        = r_ivl;
        n_valid      = r_valid;
        n_idx        = r_idx;
        n_issued     = r_issued;
        n_rd_vld     = 1'b0;
        n_found      = r_found;
        n_best_np    = r_best_np;
        n_best_start = r_best_start;
        n_best_idx   = r_best_idx;
        n_res_status = r_res_status;
        n_res_time   = r_res_time;
        n_res_slot   = r_res_slot;
        n_out_vld    = r_out_vld;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;

        if (i_cfg_valid) begin
            n_ivl = i_cfg_data;
        end
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                n_idx    = '0;
                n_issued = 1'b0;
                n_found  = 1'b0;
                if (w_s_acc) begin
                    n_state = (i_s_tuser[0] == CMD_ADD) ? S_ADD : S_REQ;
                end
            end
            S_ADD: begin
                n_res_time = '0;
                if (!r_valid[r_idx]) begin
                    n_valid[r_idx] = 1'b1;
                    n_res_status   = ST_ADDED;
                    n_res_slot     = r_idx;
                    n_state        = S_OUT;
                end else if (r_idx == LAST_IDX) begin
                    n_res_status = ST_FULL;
                    n_res_slot   = '0;
                    n_state      = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_REQ: begin
                if (!r_issued) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_issued = (r_idx == LAST_IDX);
                end
                if (r_rd_vld && r_valid[r_rd_idx]) begin
                    if (r_rd_end < r_now) begin
                        n_valid[r_rd_idx] = 1'b0;
                    end else if (w_better) begin
                        n_found      = 1'b1;
                        n_best_np    = r_rd_np;
                        n_best_start = r_rd_start;
                        n_best_idx   = r_rd_idx;
                    end
                end
                if (r_rd_vld && (r_rd_idx == LAST_IDX)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_found) begin
                    n_res_status = ST_PACKET;
                    n_res_time   = r_best_np;
                    n_res_slot   = r_best_idx;
                end else begin
                    n_res_status = ST_EMPTY;
                    n_res_time   = '0;
                    n_res_slot   = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_tdata = {{(M_TDATA_W - FIELD_W - SLOT_W){1'b0}},
                                   w_res_slot_ext[SLOT_W-1:0],
                                   w_res_time_ext[FIELD_W-1:0]};
                    n_out_tuser = r_res_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ivl     <= PKT_IVL_RST;
            r_valid   <= '0;
            r_idx     <= '0;
            r_issued  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ivl     <= n_ivl;
            r_valid   <= n_valid;
            r_idx     <= n_idx;
            r_issued  <= n_issued;
            r_rd_vld  <= n_rd_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_idx;
        r_best_np    <= n_best_np;
        r_best_start <= n_best_start;
        r_best_idx   <= n_best_idx;
        r_res_status <= n_res_status;
        r_res_time   <= n_res_time;
        r_res_slot   <= n_res_slot;
        r_out_tdata  <= n_out_tdata;
        r_out_tuser  <= n_out_tuser;
        if (w_s_acc) begin
            r_cmd   <= i_s_tuser[0];
            r_start <= w_in_start[TIME_BITS-1:0];
            r_end   <= w_in_end[TIME_BITS-1:0];
            r_now   <= w_in_now[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add_we && (r_cmd == CMD_ADD)) begin
            r_mem_start[r_idx] <= r_start;
            r_mem_end[r_idx]   <= r_end;
        end
        if (w_np_we) begin
            r_mem_np[w_np_addr] <= w_np_data;
        end
        r_rd_start <= r_mem_start[r_idx];
        r_rd_end   <= r_mem_end[r_idx];
        r_rd_np    <= r_mem_np[r_idx];
    end

endmodule

`default_nettype wire

### rtl/eps_checker.sv
// ----------------------------------------------------------------------------
// Earliest packet call scheduler checker
// Port-level assertions on the scheduler, attached to the scheduler by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_checker
    import eps_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic [S_TDATA_W-1:0] i_s_tdata,
    input wire logic [S_TUSER_W-1:0] i_s_tuser,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [M_TUSER_W-1:0] o_m_tuser,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [IVL_W-1:0]     i_cfg_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown straight after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready again in the cycle after an item");

    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_PACKET) |-> (o_m_tdata[31:0] == 32'd0))
        else $error("arrival time set on a result without a packet");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == ST_EMPTY) || (o_m_tuser == ST_FULL))
        |-> (o_m_tdata[35:32] == 4'd0))
        else $error("slot set on an empty or full result");

endmodule

bind earliest_packet_call_scheduler eps_checker u_eps_checker (.*);

`default_nettype wire

### tb/eps_sched_checker.sv
// ----------------------------------------------------------------------------
// Earliest packet call scheduler checker
// Watches the command, result and interval channels. It keeps its own copy of
// the call table and the packet interval and works out the answer to every
// accepted command. It compares each result field by field with the oldest
// answer still due, and hands the failure count and the number of answers
// still due to the testbench top.
// ----------------------------------------------------------------------------
module eps_sched_checker
    import eps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // tdata: start_time, end_time, now (lowest bits first)
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: cmd
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // tdata: arrival_time, slot, zero padding (lowest bits first)
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,
    // tuser: status
    input  wire logic [M_TUSER_W-1:0] i_m_tuser,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [IVL_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_CALLS_DEF;
    localparam logic [FIELD_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  arrival;
        logic [SLOT_W-1:0]   slot;
    } sched_result_t;

    logic [FIELD_W-1:0] start_at [SLOTS];
    logic [FIELD_W-1:0] end_at   [SLOTS];
    logic [FIELD_W-1:0] next_pkt [SLOTS];
    bit                 live     [SLOTS];
    logic [IVL_W-1:0]   pkt_interval = PKT_IVL_RST;
    sched_result_t      due_results [$];
    int                 fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic sched_result_t schedule_step(input logic cmd,
                                                    input logic [FIELD_W-1:0] st,
                                                    input logic [FIELD_W-1:0] et,
                                                    input logic [FIELD_W-1:0] nw);
        sched_result_t    res;
        int               best;
        logic [FIELD_W:0] sum;
        res = '{ST_FULL, '0, '0};
        best = -1;
        if (cmd == CMD_ADD) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i] && best < 0) best = i;
            end
            if (best >= 0) begin
                live[best] = 1'b1;
                start_at[best] = st;
                end_at[best] = et;
                next_pkt[best] = st;
                res = '{ST_ADDED, '0, SLOT_W'(best)};
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (live[i] && end_at[i] < nw) live[i] = 1'b0;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (live[i] && (best < 0 || next_pkt[i] < next_pkt[best] ||
                                (next_pkt[i] == next_pkt[best] &&
                                 start_at[i] < start_at[best]))) begin
                    best = i;
                end
            end
            if (best < 0) begin
                res = '{ST_EMPTY, '0, '0};
            end else begin
                res = '{ST_PACKET, next_pkt[best], SLOT_W'(best)};
                sum = {1'b0, next_pkt[best]} + pkt_interval;
                next_pkt[best] = (sum >= {1'b0, TIME_MAX}) ? TIME_MAX : sum[FIELD_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        sched_result_t seen;
        sched_result_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
            pkt_interval = PKT_IVL_RST;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) pkt_interval = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                seen = '{i_m_tuser, i_m_tdata[FIELD_W-1:0], i_m_tdata[FIELD_W+:SLOT_W]};
                if (due_results.size() == 0) begin
                    $display("%0t: result with none due: status %0d arrival %h slot %0d",
                             $time, seen.status, seen.arrival, seen.slot);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (seen.status != want.status || seen.arrival != want.arrival ||
                        seen.slot != want.slot ||
                        i_m_tdata[M_TDATA_W-1:FIELD_W+SLOT_W] != '0) begin
                        $display("%0t: mismatch: expected status %0d arrival %h slot %0d, %s",
                                 $time, want.status, want.arrival, want.slot, "got");
                        $display("%0t:           actual   status %0d arrival %h slot %0d pad %h",
                                 $time, seen.status, seen.arrival, seen.slot,
                                 i_m_tdata[M_TDATA_W-1:FIELD_W+SLOT_W]);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_results.push_back(schedule_step(i_s_tuser[0],
                                                    i_s_tdata[0+:FIELD_W],
                                                    i_s_tdata[FIELD_W+:FIELD_W],
                                                    i_s_tdata[2*FIELD_W+:FIELD_W]));
            end
        end
        o_fail_count <= fails;
        o_pending <= due_results.size();
    end

endmodule

### tb/tb_earliest_packet_call_scheduler.sv
// ----------------------------------------------------------------------------
// Earliest packet call scheduler testbench
// Drives add and request commands into the scheduler: a directed opening that
// fills the table, checks ties, expiry, saturation and a zero interval, then
// randomised bursts of calls and requests under three idling patterns, with
// one long stall of the result channel. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_earliest_packet_call_scheduler;
    import eps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 600;
    localparam int HOLD_CYCLES = 400;
    localparam logic [FIELD_W-1:0] TIME_MAX = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IVL_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   tx_phase = 0;
    int                   sent = 0;

    always #5 clk = ~clk;

    earliest_packet_call_scheduler dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    eps_sched_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic send_cmd(input logic cmd, input logic [FIELD_W-1:0] st,
                            input logic [FIELD_W-1:0] et, input logic [FIELD_W-1:0] nw);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {nw, et, st};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic add_call(input logic [FIELD_W-1:0] st, input logic [FIELD_W-1:0] et);
        send_cmd(CMD_ADD, st, et, $urandom);
    endtask

    task automatic request(input logic [FIELD_W-1:0] nw);
        send_cmd(CMD_REQ, $urandom, $urandom, nw);
    endtask

    task automatic write_interval(input logic [IVL_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n_items);
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] st;
        logic [FIELD_W-1:0] nw;
        int                 target;
        int                 adds;
        int                 reqs;
        target = sent + n_items;
        while (sent < target) begin
            base = $urandom;
            adds = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 6);
            reqs = $urandom_range(1, 10);
            nw = base;
            for (int i = 0; i < adds; i++) begin
                st = base + $urandom_range(0, 200000);
                add_call(st, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : st + $urandom_range(0, 400000));
            end
            for (int i = 0; i < reqs; i++) begin
                nw = nw + $urandom_range(0, 80000);
                if ($urandom_range(0, 5) == 0) add_call(nw, nw + $urandom_range(0, 200000));
                else request(nw);
            end
            case ($urandom_range(0, 9))
                0: request(TIME_MAX);
                1: request('0);
                2: repeat ($urandom_range(1, 4)) begin
                    send_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
                end
                default: ;
            endcase
        end
    endtask

    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && tx_phase == 2 && m_tvalid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        request($urandom);
        add_call('0, TIME_MAX - 2);
        add_call(TIME_MAX, TIME_MAX - 1);
        add_call(32'd20000, TIME_MAX - 2);
        for (int i = 3; i < 15; i++) add_call(32'd100, 32'd5);
        add_call('0, TIME_MAX - 2);
        add_call($urandom, $urandom);
        request('0);
        request('0);
        request(32'd5);
        request(32'd6);
        request(32'd6);
        request(32'd6);

        write_interval('1);
        request(TIME_MAX - 1);
        add_call(TIME_MAX - 15, TIME_MAX - 1);
        request(TIME_MAX - 1);
        request(TIME_MAX - 1);

        write_interval('0);
        add_call(32'd7, TIME_MAX - 1);
        request(TIME_MAX - 1);
        request(TIME_MAX - 1);
        request(TIME_MAX);
        request($urandom);

        tx_idle_pct = 29;
        rx_idle_pct = 66;
        write_interval(20'd1);
        run_traffic(PHASE_ITEMS);

        tx_idle_pct = 66;
        rx_idle_pct = 29;
        write_interval(20'd1000000);
        run_traffic(PHASE_ITEMS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        tx_phase = 2;
        write_interval(IVL_W'($urandom_range(1, 1000000)));
        run_traffic(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/eps_pkg.sv
rtl/earliest_packet_call_scheduler.sv
rtl/eps_checker.sv
tb/eps_sched_checker.sv
tb/tb_earliest_packet_call_scheduler.sv
